### hdl/gdea_pkg.sv
// ----------------------------------------------------------------------------
// gdea_pkg: shared types and constants of the geodetic delta ENU accumulator
// State codes, WGS84 fixed-point constants, the multiplier control group and
// the CORDIC angle table.
// ----------------------------------------------------------------------------
package gdea_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_THETA,
    ST_CORDIC,
    ST_SSQ,
    ST_E2S,
    ST_SQRT,
    ST_WQ,
    ST_DIVN,
    ST_DIVM,
    ST_GN,
    ST_FE,
    ST_GE,
    ST_NM,
    ST_EM,
    ST_ACC,
    ST_OUT
  } gdea_state_t;

  typedef struct packed {
    logic start;
    logic sh32;   // 1: shift product right by 32, 0: by 30
    logic rnd;    // 1: round half up before the shift
  } gdea_mul_ctl_t;

  localparam logic [63:0] KQ        = 64'd8048910509;
  localparam logic [63:0] E2Q       = 64'd28752143;
  localparam logic [63:0] A_MM      = 64'd6378137000;
  localparam logic [63:0] B2A_MM    = 64'd6335439327;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] CORDIC_X0   = 35'sd652032874;
  localparam logic [33:0] DELTA_CAP = 34'h2_0000_0000;

  function automatic logic signed [34:0] atan_q30(input logic [5:0] i);
    logic signed [34:0] v;
    begin
      case (i)
        6'd0:    v = 35'sh3243F6A8;
        6'd1:    v = 35'sh1DAC6705;
        6'd2:    v = 35'sh0FADBAFC;
        6'd3:    v = 35'sh07F56EA6;
        6'd4:    v = 35'sh03FEAB76;
        6'd5:    v = 35'sh01FFD55B;
        6'd6:    v = 35'sh00FFFAAA;
        6'd7:    v = 35'sh007FFF55;
        6'd8:    v = 35'sh003FFFEA;
        6'd9:    v = 35'sh001FFFFD;
        default: begin
          if (i <= 6'd30) v = 35'sd1073741824 >>> i;
          else v = '0;
        end
      endcase
      return v;
    end
  endfunction

endpackage

### hdl/gdea_mul.sv
// ----------------------------------------------------------------------------
// gdea_mul: iterative 64x64 multiply with shift, rounding and saturation
// One 32x32 multiplier builds the 128-bit product from four partial
// products, then rounds, shifts right by 30 or 32 and saturates to 64 bits.
// ----------------------------------------------------------------------------
module gdea_mul
  import gdea_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  gdea_mul_ctl_t ctl,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output logic          done,
  output logic [63:0]   p
);

  logic         busy_r;
  logic         done_r;
  logic [2:0]   ph_r;
  logic [1:0]   k_r;
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [63:0]  prod_r;
  logic [127:0] acc_r;
  logic         sh32_r;
  logic         rnd_r;
  logic [63:0]  p_r;

  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [127:0] prod_sh;
  logic [127:0] p_rnd;
  logic [63:0]  fin;

  assign pa = ph_r[1] ? a_r[63:32] : a_r[31:0];
  assign pb = ph_r[0] ? b_r[63:32] : b_r[31:0];

  always_comb begin
    case (k_r)
      2'd0:    prod_sh = {64'd0, prod_r};
      2'd3:    prod_sh = {prod_r, 64'd0};
      default: prod_sh = {32'd0, prod_r, 32'd0};
    endcase
  end

  always_comb begin
    p_rnd = acc_r;
    if (rnd_r) p_rnd = acc_r + (sh32_r ? (128'd1 << 31) : (128'd1 << 29));
    if (sh32_r) fin = (p_rnd[127:96] != '0) ? '1 : p_rnd[95:32];
    else        fin = (p_rnd[127:94] != '0) ? '1 : p_rnd[93:30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        ph_r   <= '0;
      end else if (busy_r) begin
        ph_r <= ph_r + 3'd1;
        if (ph_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r    <= a;
      b_r    <= b;
      sh32_r <= ctl.sh32;
      rnd_r  <= ctl.rnd;
      acc_r  <= '0;
    end else if (busy_r) begin
      if (ph_r <= 3'd3) begin
        prod_r <= 64'(pa) * 64'(pb);
        k_r    <= ph_r[1:0];
      end
      if (ph_r >= 3'd1 && ph_r <= 3'd4) acc_r <= acc_r + prod_sh;
      if (ph_r == 3'd5) p_r <= fin;
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

### hdl/geodetic_delta_enu_accumulator.sv
// ----------------------------------------------------------------------------
// geodetic_delta_enu_accumulator: GNSS fix stream to running ENU offset
// Scales each latitude and longitude step by WGS84 radii at the current
// latitude and adds north, east and up offsets with saturation.
//
//  channel | dir | tdata (low bit up)                   | tuser
//  in_     | in  | lat_e7[30:0] lon_e7[62:31] alt[88:63] | -
//  out_    | out | east[31:0] north[63:32] up[95:64]     | ignored[0] init[1]
//
// A zero or first fix gives its result beat in the cycle after the input beat.
// A moving fix passes through the shared 32x32 multiplier (9 uses), the 32-step
// square root and two 64-step dividers before its result beat. The next fix is
// taken only after the result beat of the last one has been taken.
// in_tready is high only in idle; a result beat holds until out_tready.
// Reset clears the sums, the stored last fix and the initialized flag.
// ----------------------------------------------------------------------------
module geodetic_delta_enu_accumulator
  import gdea_pkg::*;
#(
  parameter int CORDIC_STEPS = 32
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // lat_e7[30:0], lon_e7[62:31], alt_mm[88:63]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // east_mm[31:0], north_mm[63:32], up_mm[95:64]
  output logic [1:0]  out_tuser   // fix_ignored[0], is_initialized[1]
);

  localparam int IW = $clog2(CORDIC_STEPS);

  gdea_state_t state_r, state_nxt;

  logic                 init_r;
  logic                 ign_r;
  logic                 go_r;
  logic signed [30:0]   lat_r;
  logic signed [31:0]   lon_r;
  logic signed [25:0]   alt_r;
  logic signed [31:0]   last_lat_r;
  logic signed [31:0]   last_lon_r;
  logic signed [25:0]   last_alt_r;
  logic signed [31:0]   sum_e_r;
  logic signed [31:0]   sum_n_r;
  logic signed [31:0]   sum_u_r;
  logic signed [34:0]   th_r;
  logic                 negcos_r;
  logic signed [34:0]   x_r;
  logic signed [34:0]   y_r;
  logic [IW-1:0]        i_r;
  logic [5:0]           k_r;
  logic [31:0]          s2_r;
  logic [30:0]          w_r;
  logic [63:0]          n_r;
  logic [63:0]          rt_r;
  logic [63:0]          bit_r;
  logic [31:0]          q_r;
  logic [31:0]          wq_r;
  logic [32:0]          rem_r;
  logic [63:0]          dq_r;
  logic [31:0]          dvs_r;
  logic [63:0]          rn_r;
  logic [63:0]          rm_r;
  logic [63:0]          gn_r;
  logic [63:0]          t_r;
  logic [63:0]          nm_r;

  gdea_mul_ctl_t mul_ctl;
  logic [63:0]   mul_a;
  logic [63:0]   mul_b;
  logic          mul_done;
  logic [63:0]   mul_p;
  logic          mul_st;

  logic signed [30:0]   in_lat;
  logic signed [31:0]   in_lon;
  logic signed [25:0]   in_alt;
  logic                 in_zero;
  logic [30:0]          lat_abs;
  logic [34:0]          y_abs;
  logic [34:0]          x_abs;
  logic                 c_neg;
  logic signed [34:0]   th_s;
  logic signed [34:0]   th_fold;
  logic                 fold;
  logic signed [34:0]   atan_i;
  logic signed [34:0]   w_calc;
  logic [63:0]          sq_sum;
  logic                 sq_ge;
  logic [63:0]          rt_nxt;
  logic [33:0]          rem2;
  logic                 dv_ge;
  logic [63:0]          dq_nxt;
  logic signed [63:0]   fn_s;
  logic signed [63:0]   fe_s;
  logic signed [32:0]   dlat;
  logic signed [32:0]   dlon;
  logic [32:0]          dlat_abs;
  logic [32:0]          dlon_abs;
  logic signed [35:0]   dn;
  logic signed [35:0]   de;
  logic signed [35:0]   du;

  function automatic logic signed [35:0] cap_sign(input logic [63:0] mag, input logic neg);
    logic [33:0] m;
    begin
      m = (mag > 64'(DELTA_CAP)) ? DELTA_CAP : mag[33:0];
      return neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
    end
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] s,
                                                  input logic signed [35:0] d);
    logic signed [35:0] t;
    begin
      t = 36'(s) + d;
      if (t > 36'sd2147483647) return 32'sh7FFFFFFF;
      if (t < -36'sd2147483648) return 32'sh80000000;
      return t[31:0];
    end
  endfunction

  gdea_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign in_lat  = in_tdata[30:0];
  assign in_lon  = in_tdata[62:31];
  assign in_alt  = in_tdata[88:63];
  assign in_zero = (in_lat == '0) && (in_lon == '0);

  assign lat_abs = lat_r[30] ? 31'(-lat_r) : 31'(lat_r);
  assign y_abs   = y_r[34] ? 35'(-y_r) : 35'(y_r);
  assign x_abs   = x_r[34] ? 35'(-x_r) : 35'(x_r);
  assign c_neg   = negcos_r ? (x_r > 35'sd0) : x_r[34];

  // fold the angle into [-pi/2, pi/2]; the cosine flips sign there
  always_comb begin
    th_s = lat_r[30] ? -$signed({1'b0, mul_p[33:0]}) : $signed({1'b0, mul_p[33:0]});
    fold = 1'b0;
    th_fold = th_s;
    if (th_s > HALF_PI_Q30) begin
      th_fold = PI_Q30 - th_s;
      fold = 1'b1;
    end else if (th_s < -HALF_PI_Q30) begin
      th_fold = -PI_Q30 - th_s;
      fold = 1'b1;
    end
  end

  assign atan_i = atan_q30(6'(i_r));

  always_comb begin
    w_calc = 35'sd1073741824 - $signed({1'b0, mul_p[33:0]});
    if (w_calc[34]) w_calc = '0;
  end

  assign sq_sum = rt_r + bit_r;
  assign sq_ge  = n_r >= sq_sum;
  assign rt_nxt = sq_ge ? ((rt_r >> 1) + bit_r) : (rt_r >> 1);

  assign rem2   = {rem_r, dq_r[63]};
  assign dv_ge  = rem2 >= {2'b00, dvs_r};
  assign dq_nxt = {dq_r[62:0], dv_ge};

  always_comb begin
    fn_s = $signed(rm_r) + 64'(alt_r);
    fe_s = $signed(rn_r) + 64'(alt_r);
    if (fn_s[63]) fn_s = '0;
    if (fe_s[63]) fe_s = '0;
  end

  assign dlat     = 33'(lat_r) - 33'(last_lat_r);
  assign dlon     = 33'(lon_r) - 33'(last_lon_r);
  assign dlat_abs = dlat[32] ? 33'(-dlat) : 33'(dlat);
  assign dlon_abs = dlon[32] ? 33'(-dlon) : 33'(dlon);
  assign dn       = cap_sign(nm_r, dlat[32]);
  assign de       = cap_sign(t_r, dlon[32] != c_neg);
  assign du       = 36'(alt_r) - 36'(last_alt_r);

  assign mul_st = state_r inside {ST_THETA, ST_SSQ, ST_E2S, ST_WQ, ST_GN, ST_FE,
                                  ST_GE, ST_NM, ST_EM};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = (in_zero || !init_r) ? ST_OUT : ST_THETA;
      ST_THETA:  if (go_r && mul_done) state_nxt = ST_CORDIC;
      ST_CORDIC: if (i_r == IW'(CORDIC_STEPS - 1)) state_nxt = ST_SSQ;
      ST_SSQ:    if (go_r && mul_done) state_nxt = ST_E2S;
      ST_E2S:    if (go_r && mul_done) state_nxt = ST_SQRT;
      ST_SQRT:   if (k_r == 6'd31) state_nxt = ST_WQ;
      ST_WQ:     if (go_r && mul_done) state_nxt = ST_DIVN;
      ST_DIVN:   if (k_r == 6'd63) state_nxt = ST_DIVM;
      ST_DIVM:   if (k_r == 6'd63) state_nxt = ST_GN;
      ST_GN:     if (go_r && mul_done) state_nxt = ST_FE;
      ST_FE:     if (go_r && mul_done) state_nxt = ST_GE;
      ST_GE:     if (go_r && mul_done) state_nxt = ST_NM;
      ST_NM:     if (go_r && mul_done) state_nxt = ST_EM;
      ST_EM:     if (go_r && mul_done) state_nxt = ST_ACC;
      ST_ACC:    state_nxt = ST_OUT;
      ST_OUT:    if (out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs and multiplier operands
  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    out_tvalid    = (state_r == ST_OUT);
    mul_ctl.start = mul_st && !go_r;
    mul_ctl.sh32  = 1'b0;
    mul_ctl.rnd   = 1'b1;
    mul_a         = '0;
    mul_b         = '0;
    case (state_r)
      ST_THETA: begin
        mul_a = 64'(lat_abs);
        mul_b = KQ;
        mul_ctl.sh32 = 1'b1;
      end
      ST_SSQ: begin
        mul_a = 64'(y_abs);
        mul_b = 64'(y_abs);
        mul_ctl.rnd = 1'b0;
      end
      ST_E2S: begin
        mul_a = 64'(s2_r);
        mul_b = E2Q;
        mul_ctl.sh32 = 1'b1;
        mul_ctl.rnd = 1'b0;
      end
      ST_WQ: begin
        mul_a = 64'(w_r);
        mul_b = 64'(q_r);
      end
      ST_GN: begin
        mul_a = fn_s;
        mul_b = KQ;
      end
      ST_FE: begin
        mul_a = fe_s;
        mul_b = 64'(x_abs);
      end
      ST_GE: begin
        mul_a = t_r;
        mul_b = KQ;
      end
      ST_NM: begin
        mul_a = gn_r;
        mul_b = 64'(dlat_abs);
        mul_ctl.sh32 = 1'b1;
      end
      ST_EM: begin
        mul_a = t_r;
        mul_b = 64'(dlon_abs);
        mul_ctl.sh32 = 1'b1;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      init_r     <= 1'b0;
      ign_r      <= 1'b0;
      go_r       <= 1'b0;
      last_lat_r <= '0;
      last_lon_r <= '0;
      last_alt_r <= '0;
      sum_e_r    <= '0;
      sum_n_r    <= '0;
      sum_u_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (mul_st) begin
        if (!go_r) go_r <= 1'b1;
        else if (mul_done) go_r <= 1'b0;
      end
      if (state_r == ST_IDLE && in_tvalid) begin
        ign_r <= in_zero;
        if (!in_zero && !init_r) begin
          init_r     <= 1'b1;
          sum_e_r    <= '0;
          sum_n_r    <= '0;
          sum_u_r    <= '0;
          last_lat_r <= 32'(in_lat);
          last_lon_r <= in_lon;
          last_alt_r <= in_alt;
        end
      end
      if (state_r == ST_ACC) begin
        sum_n_r    <= sat_add(sum_n_r, dn);
        sum_e_r    <= sat_add(sum_e_r, de);
        sum_u_r    <= sat_add(sum_u_r, du);
        last_lat_r <= 32'(lat_r);
        last_lon_r <= lon_r;
        last_alt_r <= alt_r;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        lat_r <= in_lat;
        lon_r <= in_lon;
        alt_r <= in_alt;
      end
      ST_THETA: begin
        if (go_r && mul_done) begin
          th_r     <= th_fold;
          negcos_r <= fold;
          x_r      <= CORDIC_X0;
          y_r      <= '0;
          i_r      <= '0;
        end
      end
      ST_CORDIC: begin
        if (!th_r[34]) begin
          x_r  <= x_r - (y_r >>> i_r);
          y_r  <= y_r + (x_r >>> i_r);
          th_r <= th_r - atan_i;
        end else begin
          x_r  <= x_r + (y_r >>> i_r);
          y_r  <= y_r - (x_r >>> i_r);
          th_r <= th_r + atan_i;
        end
        i_r <= i_r + 1'b1;
      end
      ST_SSQ: if (go_r && mul_done) s2_r <= mul_p[31:0];
      ST_E2S: begin
        if (go_r && mul_done) begin
          w_r   <= w_calc[30:0];
          n_r   <= {3'b000, w_calc[30:0], 30'd0};
          rt_r  <= '0;
          bit_r <= 64'd1 << 62;
          k_r   <= '0;
        end
      end
      ST_SQRT: begin
        if (sq_ge) n_r <= n_r - sq_sum;
        rt_r  <= rt_nxt;
        bit_r <= bit_r >> 2;
        k_r   <= k_r + 6'd1;
        if (k_r == 6'd31) q_r <= (rt_nxt == '0) ? 32'd1 : rt_nxt[31:0];
      end
      ST_WQ: begin
        if (go_r && mul_done) begin
          wq_r  <= (mul_p == '0) ? 32'd1 : mul_p[31:0];
          dq_r  <= (A_MM << 30) + 64'(q_r >> 1);
          rem_r <= '0;
          dvs_r <= q_r;
          k_r   <= '0;
        end
      end
      ST_DIVN, ST_DIVM: begin
        if (k_r == 6'd63 && state_r == ST_DIVN) begin
          // load the meridian divide once the prime-vertical one ends
          rn_r  <= dq_nxt;
          dq_r  <= (B2A_MM << 30) + 64'(wq_r >> 1);
          rem_r <= '0;
          dvs_r <= wq_r;
          k_r   <= '0;
        end else begin
          rem_r <= dv_ge ? 33'(rem2 - {2'b00, dvs_r}) : rem2[32:0];
          dq_r  <= dq_nxt;
          k_r   <= k_r + 6'd1;
          if (k_r == 6'd63) rm_r <= dq_nxt;
        end
      end
      ST_GN: if (go_r && mul_done) gn_r <= mul_p;
      ST_FE, ST_GE, ST_EM: if (go_r && mul_done) t_r <= mul_p;
      ST_NM: if (go_r && mul_done) nm_r <= mul_p;
      default: begin
        k_r <= k_r;
      end
    endcase
  end

  assign out_tdata = {sum_u_r, sum_n_r, sum_e_r};
  assign out_tuser = {init_r, ign_r};

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the geodetic delta ENU accumulator
// Drives GNSS fixes on the input stream, predicts each result beat with its
// own fixed-point model of the radii, CORDIC and accumulation, and compares
// every output beat field by field under random idling and back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import gdea_pkg::*;

  localparam int STEPS       = 32;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [31:0] east;
    logic [31:0] north;
    logic [31:0] up;
    logic        ignored;
    logic        init;
  } enu_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;   // lat_e7[30:0], lon_e7[62:31], alt_mm[88:63]
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;  // east_mm[31:0], north_mm[63:32], up_mm[95:64]
  logic [1:0]  out_tuser;  // fix_ignored[0], is_initialized[1]

  enu_beat_t   pending_enu[$];
  int          err_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_left;
  int          cycle_count;

  // predictor state
  logic               have_fix;
  logic signed [63:0] prev_lat, prev_lon, prev_alt;
  logic signed [63:0] acc_east, acc_north, acc_up;

  // walk position of the random stimulus
  longint walk_lat, walk_lon, walk_alt;

  geodetic_delta_enu_accumulator #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                            input int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  function automatic logic [63:0] root_q(input logic [63:0] n);
    logic [63:0] r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [63:0] add_sat32(input logic signed [63:0] s,
                                                   input logic [63:0] mag, input logic neg);
    logic signed [63:0] d, t;
    if (mag > 64'(DELTA_CAP)) mag = 64'(DELTA_CAP);
    d = neg ? -$signed(mag) : $signed(mag);
    t = s + d;
    if (t > 64'sd2147483647) return 64'sd2147483647;
    if (t < -64'sd2147483648) return -64'sd2147483648;
    return t;
  endfunction

  function automatic enu_beat_t predict_enu(input logic [30:0] lat_in, input logic [31:0] lon_in,
                                            input logic [25:0] alt_in);
    logic signed [63:0] lat, lon, alt, th, x, y, a, xs, ys, c, s2, w, fn, fe, dlat, dlon;
    logic [63:0] q, wq, rn, rm, gn, ge, fe_mag, nm, em;
    logic negcos;
    logic ignored;
    enu_beat_t r;
    lat = {{33{lat_in[30]}}, lat_in};
    lon = {{32{lon_in[31]}}, lon_in};
    alt = {{38{alt_in[25]}}, alt_in};
    ignored = 1'b0;
    if (lat == 0 && lon == 0) begin
      ignored = 1'b1;
    end else if (!have_fix) begin
      have_fix = 1'b1;
      acc_east = 0; acc_north = 0; acc_up = 0;
      prev_lat = lat; prev_lon = lon; prev_alt = alt;
    end else begin
      th = mul_round(mag64(lat), KQ, 32);
      if (lat < 0) th = -th;
      negcos = 1'b0;
      // fold beyond the pole and flip the cosine
      if (th > HALF_PI_Q30) begin
        th = PI_Q30 - th;
        negcos = 1'b1;
      end else if (th < -HALF_PI_Q30) begin
        th = -PI_Q30 - th;
        negcos = 1'b1;
      end
      x = CORDIC_X0;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
        case (i)
          0: a = 64'h3243F6A8;
          1: a = 64'h1DAC6705;
          2: a = 64'h0FADBAFC;
          3: a = 64'h07F56EA6;
          4: a = 64'h03FEAB76;
          5: a = 64'h01FFD55B;
          6: a = 64'h00FFFAAA;
          7: a = 64'h007FFF55;
          8: a = 64'h003FFFEA;
          9: a = 64'h001FFFFD;
          default: a = (i <= 30) ? (64'sd1 <<< (30 - i)) : 64'sd0;
        endcase
        xs = x >>> i;
        ys = y >>> i;
        if (th >= 0) begin
          x = x - ys; y = y + xs; th = th - a;
        end else begin
          x = x + ys; y = y - xs; th = th + a;
        end
      end
      c = negcos ? -x : x;
      s2 = $signed(64'(y * y) >> 30);
      w = (64'sd1 <<< 30) - $signed((64'(s2) * E2Q) >> 32);
      if (w < 0) w = 0;
      q = root_q(64'(w) << 30);
      if (q == 0) q = 1;
      wq = mul_round(w, q, 30);
      if (wq == 0) wq = 1;
      rn = ((A_MM << 30) + q / 2) / q;
      rm = ((B2A_MM << 30) + wq / 2) / wq;
      fn = $signed(rm) + alt;
      fe = $signed(rn) + alt;
      if (fn < 0) fn = 0;
      if (fe < 0) fe = 0;
      gn = mul_round(fn, KQ, 30);
      fe_mag = mul_round(fe, mag64(c), 30);
      ge = mul_round(fe_mag, KQ, 30);
      dlat = lat - prev_lat;
      dlon = lon - prev_lon;
      nm = mul_round(gn, mag64(dlat), 32);
      em = mul_round(ge, mag64(dlon), 32);
      acc_north = add_sat32(acc_north, nm, dlat < 0);
      acc_east = add_sat32(acc_east, em, (dlon < 0) != (c < 0));
      acc_up = add_sat32(acc_up, mag64(alt - prev_alt), (alt - prev_alt) < 0);
      prev_lat = lat; prev_lon = lon; prev_alt = alt;
    end
    r.east = acc_east[31:0];
    r.north = acc_north[31:0];
    r.up = acc_up[31:0];
    r.ignored = ignored;
    r.init = have_fix;
    return r;
  endfunction

  task automatic send_fix(input longint lat, input longint lon, input longint alt);
    logic [30:0] lat_b;
    logic [31:0] lon_b;
    logic [25:0] alt_b;
    lat_b = lat[30:0];
    lon_b = lon[31:0];
    alt_b = alt[25:0];
    if ($urandom_range(0, 99) < send_idle_pct) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, alt_b, lon_b, lat_b};
    do @(posedge clk); while (!in_tready);
    pending_enu.push_back(predict_enu(lat_b, lon_b, alt_b));
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_enu.size() != 0) @(posedge clk);
  endtask

  // result beat checker
  always @(posedge clk) begin
    enu_beat_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_enu.size() == 0) begin
        $display("%0t: unexpected beat %h user %b", $time, out_tdata, out_tuser);
        err_count++;
      end else begin
        e = pending_enu.pop_front();
        if (out_tdata[31:0] !== e.east) begin
          $display("%0t: east exp %0d got %0d", $time, $signed(e.east),
                   $signed(out_tdata[31:0]));
          err_count++;
        end
        if (out_tdata[63:32] !== e.north) begin
          $display("%0t: north exp %0d got %0d", $time, $signed(e.north),
                   $signed(out_tdata[63:32]));
          err_count++;
        end
        if (out_tdata[95:64] !== e.up) begin
          $display("%0t: up exp %0d got %0d", $time, $signed(e.up),
                   $signed(out_tdata[95:64]));
          err_count++;
        end
        if (out_tuser[0] !== e.ignored) begin
          $display("%0t: ignored exp %b got %b", $time, e.ignored, out_tuser[0]);
          err_count++;
        end
        if (out_tuser[1] !== e.init) begin
          $display("%0t: init exp %b got %b", $time, e.init, out_tuser[1]);
          err_count++;
        end
      end
    end
  end

  // receiver ready, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_first_fix;
    send_fix(0, 0, 12345);            // zero fix before any valid fix
    send_fix(123456789, -987654321, 5000);
    send_fix(0, 0, -1000000);         // zero fix after init keeps the sums
    send_fix(123456790, -987654300, 5100);
    drain();
  endtask

  task automatic test_extremes;
    send_fix(900000000, 1800000000, 20000000);
    send_fix(-900000000, -1800000000, -1000000);
    send_fix(900000000, 1800000000, 20000000);
    send_fix(-900000000, -1800000000, -1000000);
    send_fix(0, 1, 0);
    send_fix(1, 0, 0);
    send_fix(-1, -1, 1);
    send_fix(1073741823, 5, 0);       // beyond the pole
    send_fix(-1073741824, -5, 0);
    send_fix(1000000000, 1800000000, 20000000);
    send_fix(450000000, -1800000000, 0);
    send_fix(450000000, 1800000000, 20000000);
    send_fix(450000000, -1800000000, -1000000);
    send_fix(899999999, 1800000000, 33554431);
    send_fix(899999999, -1800000000, -33554432);
    drain();
  endtask

  task automatic random_fix;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      send_fix(0, 0, longint'($urandom_range(0, 21000000)) - 1000000);
    end else if (sel < 20) begin
      walk_lat = longint'($urandom_range(0, 1800000000)) - 900000000;
      walk_lon = longint'($urandom_range(0, 3600000000)) - 1800000000;
      walk_alt = longint'($urandom_range(0, 21000000)) - 1000000;
      send_fix(walk_lat, walk_lon, walk_alt);
    end else begin
      walk_lat = walk_lat + longint'($urandom_range(0, 40000)) - 20000;
      walk_lon = walk_lon + longint'($urandom_range(0, 40000)) - 20000;
      walk_alt = walk_alt + longint'($urandom_range(0, 4000)) - 2000;
      if (walk_lat > 900000000) walk_lat = 900000000;
      if (walk_lat < -900000000) walk_lat = -900000000;
      if (walk_lon > 1800000000) walk_lon = 1800000000;
      if (walk_lon < -1800000000) walk_lon = -1800000000;
      if (walk_alt > 20000000) walk_alt = 20000000;
      if (walk_alt < -1000000) walk_alt = -1000000;
      send_fix(walk_lat, walk_lon, walk_alt);
    end
  endtask

  task automatic test_random(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) random_fix();
    drain();
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 3000;
    repeat (12) random_fix();
    drain();
  endtask

  initial begin
    err_count = 0;
    cycle_count = 0;
    hold_left = 0;
    send_idle_pct = 11;
    recv_idle_pct = 57;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    have_fix = 1'b0;
    prev_lat = 0; prev_lon = 0; prev_alt = 0;
    acc_east = 0; acc_north = 0; acc_up = 0;
    walk_lat = 300000000; walk_lon = 100000000; walk_alt = 50000;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_first_fix();
    test_extremes();
    test_random(470, 11, 57);
    test_random(470, 57, 11);
    test_backpressure();
    test_random(470, 0, 0);

    repeat (400) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/gdea_pkg.sv
hdl/gdea_mul.sv
hdl/geodetic_delta_enu_accumulator.sv
tb/sv/testbench.sv
